[design/sctu_pkg.sv]
package sctu_pkg;

	localparam int PolyTermsDefault = 6;
	localparam int PolyTermsMax = 8;

	localparam logic [1:0] OP_SIN = 2'd0;
	localparam logic [1:0] OP_COS = 2'd1;
	localparam logic [1:0] OP_TAN = 2'd2;
	// bit 1 selects tangent, so this code acts as tangent too
	localparam logic [1:0] OP_TAN_ALT = 2'd3;

	localparam logic signed [31:0] INV_TWO_PI = 32'sd683565276;
	localparam logic [47:0] QUARTER_TURN = 48'h4000_0000_0000;
	localparam int QuotBits = 56;

	typedef struct packed {
		logic [1:0] operation;
		logic signed [31:0] angle;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic saturated;
	} out_word_t;

	typedef logic signed [39:0] coef_t;

	function automatic coef_t sin_coef(input int i);
		case (i)
			0: sin_coef = 40'sd106;
			1: sin_coef = 40'sd843309761;
			2: sin_coef = 40'sd51144;
			3: sin_coef = -40'sd86895339;
			4: sin_coef = 40'sd329095;
			5: sin_coef = 40'sd2455479;
			default: sin_coef = 40'sd0;
		endcase
	endfunction

	function automatic coef_t cos_coef(input int i);
		case (i)
			0: cos_coef = 40'sd1073742103;
			1: cos_coef = -40'sd13799;
			2: cos_coef = -40'sd331024046;
			3: cos_coef = -40'sd594132;
			4: cos_coef = 40'sd18157365;
			5: cos_coef = -40'sd1017093;
			default: cos_coef = 40'sd0;
		endcase
	endfunction

	// rounded Q30 product, half away from zero
	function automatic coef_t mul_q30(input coef_t y, input logic [30:0] x);
		logic neg;
		logic [39:0] m;
		logic [70:0] p;
		logic [40:0] r;
		neg = y[39];
		m = neg ? 40'(-y) : 40'(y);
		p = 71'(m) * 71'(x);
		r = 41'((p + 71'(1 << 29)) >> 30);
		mul_q30 = neg ? -coef_t'(r) : coef_t'(r);
	endfunction

endpackage

[design/sctu_reduce.sv]
// angle to octant, polynomial argument and sign; two register stages
module sctu_reduce (
	input logic clk,
	input logic en,
	input logic signed [31:0] angle,
	input logic add_quarter,
	output logic [30:0] x,
	output logic use_cos,
	output logic neg
);
	logic signed [63:0] turns_s1;
	logic add_q_s1;
	logic [47:0] mag_frac;
	logic [47:0] frac;
	logic [2:0] oct;
	logic [44:0] off;
	logic [45:0] arg;
	logic [63:0] tq;

	always_ff @(posedge clk) begin
		if (en) begin
			turns_s1 <= 64'(angle) * 64'(sctu_pkg::INV_TWO_PI);
			add_q_s1 <= add_quarter;
		end
	end

	always_comb begin
		tq = turns_s1 + (add_q_s1 ? 64'(sctu_pkg::QUARTER_TURN) : 64'd0);
		mag_frac = tq[63] ? 48'(-tq) : tq[47:0];
		frac = mag_frac;
		oct = frac[47:45];
		off = frac[44:0];
		arg = oct[0] ? (46'(1) << 45) - 46'(off) : 46'(off);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x <= arg[45:15];
			use_cos <= oct[0] ^ oct[1];
			neg <= tq[63] ^ oct[2];
		end
	end
endmodule

[design/sctu_horner.sv]
// one Horner step per stage
module sctu_horner #(
	parameter int POLY_TERMS = sctu_pkg::PolyTermsDefault
) (
	input logic clk,
	input logic en,
	input logic [30:0] x,
	input logic use_cos,
	input logic neg,
	output sctu_pkg::coef_t y
);
	localparam int N = POLY_TERMS - 1;
	sctu_pkg::coef_t acc_s [N+1];
	logic [30:0] x_s [N+1];
	logic c_s [N+1];
	logic n_s [N+1];

	always_comb begin
		acc_s[0] = use_cos ? sctu_pkg::cos_coef(N) : sctu_pkg::sin_coef(N);
		x_s[0] = x;
		c_s[0] = use_cos;
		n_s[0] = neg;
	end

	for (genvar k = 1; k <= N; k++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				acc_s[k] <= sctu_pkg::mul_q30(acc_s[k-1], x_s[k-1]) +
					(c_s[k-1] ? sctu_pkg::cos_coef(N-k) : sctu_pkg::sin_coef(N-k));
				x_s[k] <= x_s[k-1];
				c_s[k] <= c_s[k-1];
				n_s[k] <= n_s[k-1];
			end
		end
	end

	assign y = n_s[N] ? -acc_s[N] : acc_s[N];
endmodule

[design/sctu_divider.sv]
// pipelined restoring divider, one quotient bit per stage
module sctu_divider (
	input logic clk,
	input logic en,
	input logic [55:0] num,
	input logic [31:0] den,
	input logic [2:0] tag_in,
	output logic [55:0] quot,
	output logic [2:0] tag_out
);
	localparam int B = sctu_pkg::QuotBits;
	logic [32:0] rem_s [B+1];
	logic [55:0] n_s [B+1];
	logic [55:0] q_s [B+1];
	logic [31:0] d_s [B+1];
	logic [2:0] t_s [B+1];

	always_comb begin
		rem_s[0] = '0;
		n_s[0] = num;
		q_s[0] = '0;
		d_s[0] = den;
		t_s[0] = tag_in;
	end

	for (genvar k = 1; k <= B; k++) begin : g_bit
		logic [33:0] sh;
		logic ge;
		always_comb begin
			sh = {rem_s[k-1], n_s[k-1][55]};
			ge = sh >= 34'(d_s[k-1]);
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? 33'(sh - 34'(d_s[k-1])) : sh[32:0];
				n_s[k] <= n_s[k-1] << 1;
				q_s[k] <= {q_s[k-1][54:0], ge};
				d_s[k] <= d_s[k-1];
				t_s[k] <= t_s[k-1];
			end
		end
	end

	assign quot = q_s[B];
	assign tag_out = t_s[B];
endmodule

[design/sine_cosine_tangent_unit_core.sv]
// sine / cosine / tangent of a Q15.16 radian angle, Q7.24 result
// in: valid/ready, word = {operation, angle}; out: valid/ready, word = {value, saturated}
// operation 0 sine, 1 cosine, 2 or 3 tangent (sine over cosine, clamped with saturated set)
// one word accepted per cycle while in_ready is high; all operations share one pipeline of fixed depth
// pipeline: 2 reduction stages + POLY_TERMS-1 Horner stages + 1 prep stage
//   + 56 divider stages + 1 output stage
// the divider's 56 one-bit stages set the depth; sine and cosine ride along
// the whole pipeline advances together; when the receiver stalls with the
// output register full, the pipeline freezes and in_ready drops
// reset clears the valid bits only; payload registers are left as they are
module sine_cosine_tangent_unit_core #(
	parameter int POLY_TERMS = sctu_pkg::PolyTermsDefault
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input sctu_pkg::in_word_t in_data,
	output logic out_valid,
	input logic out_ready,
	output sctu_pkg::out_word_t out_data
);
	localparam int Depth = 2 + (POLY_TERMS - 1) + 1 + sctu_pkg::QuotBits;
	logic en;
	logic [Depth-1:0] v_q;
	logic [1:0] op_s1, op_s2;

	assign en = !out_valid || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_q <= {v_q[Depth-2:0], in_valid};
			out_valid <= v_q[Depth-1];
		end
	end

	// dual path: sine (or cosine) and cosine for tangent
	logic [30:0] xa, xb;
	logic ca, cb, na, nb;
	sctu_pkg::coef_t ya, yb;

	sctu_reduce u_ra (.clk, .en, .angle(in_data.angle),
		.add_quarter(in_data.operation == sctu_pkg::OP_COS), .x(xa), .use_cos(ca), .neg(na));
	sctu_reduce u_rb (.clk, .en, .angle(in_data.angle),
		.add_quarter(1'b1), .x(xb), .use_cos(cb), .neg(nb));
	sctu_horner #(.POLY_TERMS(POLY_TERMS)) u_ha (.clk, .en, .x(xa),
		.use_cos(ca), .neg(na), .y(ya));
	sctu_horner #(.POLY_TERMS(POLY_TERMS)) u_hb (.clk, .en, .x(xb),
		.use_cos(cb), .neg(nb), .y(yb));

	// operation delay through reduce + horner
	localparam int OpDly = 2 + POLY_TERMS - 1;
	logic [1:0] op_d [OpDly+1];
	assign op_d[0] = in_data.operation;
	for (genvar k = 1; k <= OpDly; k++) begin : g_op
		always_ff @(posedge clk) if (en) op_d[k] <= op_d[k-1];
	end
	assign op_s1 = op_d[OpDly];

	// prep stage: sin/cos rounding or divider operands
	logic [55:0] num_s1;
	logic [31:0] den_s1;
	logic [2:0] tag_s1;
	logic signed [31:0] sc_s1;
	logic [39:0] ma, mb;
	logic [34:0] rnd;

	always_comb begin
		ma = ya[39] ? 40'(-ya) : 40'(ya);
		mb = yb[39] ? 40'(-yb) : 40'(yb);
		rnd = 35'((ma + 40'd32) >> 6);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s1 <= (56'(ma) << 24) + 56'(mb >> 1);
			den_s1 <= (mb == 40'd0) ? 32'd1 : mb[31:0];
			// tag: tangent, zero divisor, negative
			tag_s1 <= {op_s1[1], mb == 40'd0,
				(mb == 40'd0) ? ya[39] : (ya[39] ^ yb[39])};
			sc_s1 <= ya[39] ? -32'(rnd) : 32'(rnd);
		end
	end

	// sine/cosine value delayed alongside the divider
	localparam int SB = sctu_pkg::QuotBits;
	logic signed [31:0] sc_d [SB+1];
	assign sc_d[0] = sc_s1;
	for (genvar k = 1; k <= SB; k++) begin : g_sc
		always_ff @(posedge clk) if (en) sc_d[k] <= sc_d[k-1];
	end

	logic [55:0] quot;
	logic [2:0] tag;
	sctu_divider u_div (.clk, .en, .num(num_s1), .den(den_s1), .tag_in(tag_s1),
		.quot(quot), .tag_out(tag));

	assign op_s2 = {tag[2], 1'b0};

	logic [55:0] lim;
	assign lim = tag[0] ? 56'd2147483648 : 56'd2147483647;

	always_ff @(posedge clk) begin
		if (en) begin
			if (op_s2[1]) begin
				if (tag[1]) begin
					out_data.value <= tag[0] ? 32'h8000_0000 : 32'h7fff_ffff;
					out_data.saturated <= 1'b1;
				end else if (quot > lim) begin
					out_data.value <= tag[0] ? 32'h8000_0000 : 32'h7fff_ffff;
					out_data.saturated <= 1'b1;
				end else begin
					out_data.value <= tag[0] ? -quot[31:0] : quot[31:0];
					out_data.saturated <= 1'b0;
				end
			end else begin
				out_data.value <= sc_d[SB];
				out_data.saturated <= 1'b0;
			end
		end
	end

`ifndef SYNTH
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output word changed under stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready) else $error("ready low with empty output");
	a_sat_tan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.saturated |-> out_data.value == 32'h7fff_ffff
		|| out_data.value == 32'h8000_0000) else $error("saturated word not clamped");
`endif
endmodule
